[design/idprc_pkg.sv]
// Shared types and codes for the datagram receive checker.
// No dependencies; used by every module of the block.
`default_nettype none
package idprc_pkg;

  // Header size in bytes.
  localparam logic [15:0] HEADER_BYTES = 16'd30;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // End status codes.
  localparam logic [2:0] STATUS_NONE      = 3'd0;
  localparam logic [2:0] STATUS_OK        = 3'd1;
  localparam logic [2:0] STATUS_UNCHECKED = 3'd2;
  localparam logic [2:0] STATUS_MISMATCH  = 3'd3;
  localparam logic [2:0] STATUS_BAD_LEN   = 3'd4;

  // One result item as it travels through the queue.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [2:0]  end_status;
    logic [15:0] packet_length;
    logic [7:0]  hop_count;
    logic [7:0]  packet_type;
    logic [31:0] dest_net;
    logic [47:0] dest_host;
    logic [15:0] dest_socket;
    logic [31:0] source_net;
    logic [47:0] source_host;
    logic [15:0] source_socket;
  } result_t;

  // Request from the parser into the queue.
  typedef struct packed {
    logic    valid;
    result_t item;
  } push_t;

endpackage
`default_nettype wire

[design/idprc_front.sv]
// Front part: accepts packet bytes, parses the header, folds the checksum
// and classifies each byte into a result request. Depends on idprc_pkg.
`default_nettype none
module idprc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             stall,
  input  wire logic [7:0]       data_byte,
  input  wire logic             first_byte,
  input  wire logic [15:0]      no_checksum_value,
  output idprc_pkg::push_t      push
);

  // Parser state.
  logic        in_packet;
  logic [15:0] byte_index;
  logic [15:0] sum_accum;
  logic [7:0]  high_byte_hold;
  logic [15:0] received_checksum;
  logic [15:0] length_reg;
  logic [7:0]  hop_reg;
  logic [7:0]  type_reg;
  logic [31:0] dest_net_reg;
  logic [47:0] dest_host_reg;
  logic [15:0] dest_socket_reg;
  logic [31:0] source_net_reg;
  logic [47:0] source_host_reg;
  logic [15:0] source_socket_reg;

  logic        in_packet_next;
  logic [15:0] idx;
  logic [15:0] sum_accum_next;
  logic [7:0]  high_byte_hold_next;
  logic [15:0] received_checksum_next;
  logic [15:0] length_reg_next;
  logic [7:0]  hop_reg_next;
  logic [7:0]  type_reg_next;
  logic [31:0] dest_net_reg_next;
  logic [47:0] dest_host_reg_next;
  logic [15:0] dest_socket_reg_next;
  logic [31:0] source_net_reg_next;
  logic [47:0] source_host_reg_next;
  logic [15:0] source_socket_reg_next;

  logic        active;
  logic [15:0] last_index;
  logic        emit;
  logic [1:0]  kind;
  logic [7:0]  payload;
  logic [2:0]  status;

  // One's complement add of a word, then rotate left by one.
  function automatic logic [15:0] fold_word(input logic [15:0] acc, input logic [15:0] w);
    logic [16:0] s;
    logic [15:0] f;
    s = {1'b0, acc} + {1'b0, w};
    f = s[15:0] + {15'd0, s[16]};
    return {f[14:0], f[15]};
  endfunction

  // A byte counts when it starts a packet or arrives inside one.
  assign active = in_valid && !stall && (first_byte || in_packet);

  // Next values of the packet state; a first byte starts from cleared state.
  always_comb begin
    if (first_byte) begin
      idx                    = 16'd0;
      sum_accum_next         = 16'd0;
      high_byte_hold_next    = 8'd0;
      received_checksum_next = 16'd0;
      length_reg_next        = 16'd0;
      hop_reg_next           = 8'd0;
      type_reg_next          = 8'd0;
      dest_net_reg_next      = 32'd0;
      dest_host_reg_next     = 48'd0;
      dest_socket_reg_next   = 16'd0;
      source_net_reg_next    = 32'd0;
      source_host_reg_next   = 48'd0;
      source_socket_reg_next = 16'd0;
    end else begin
      idx                    = byte_index;
      sum_accum_next         = sum_accum;
      high_byte_hold_next    = high_byte_hold;
      received_checksum_next = received_checksum;
      length_reg_next        = length_reg;
      hop_reg_next           = hop_reg;
      type_reg_next          = type_reg;
      dest_net_reg_next      = dest_net_reg;
      dest_host_reg_next     = dest_host_reg;
      dest_socket_reg_next   = dest_socket_reg;
      source_net_reg_next    = source_net_reg;
      source_host_reg_next   = source_host_reg;
      source_socket_reg_next = source_socket_reg;
    end

    // Shift the byte into the header field that owns this position.
    priority if (idx < 16'd2) begin
      received_checksum_next = {received_checksum_next[7:0], data_byte};
    end else if (idx < 16'd4) begin
      length_reg_next = {length_reg_next[7:0], data_byte};
    end else if (idx == 16'd4) begin
      hop_reg_next = data_byte;
    end else if (idx == 16'd5) begin
      type_reg_next = data_byte;
    end else if (idx < 16'd10) begin
      dest_net_reg_next = {dest_net_reg_next[23:0], data_byte};
    end else if (idx < 16'd16) begin
      dest_host_reg_next = {dest_host_reg_next[39:0], data_byte};
    end else if (idx < 16'd18) begin
      dest_socket_reg_next = {dest_socket_reg_next[7:0], data_byte};
    end else if (idx < 16'd22) begin
      source_net_reg_next = {source_net_reg_next[23:0], data_byte};
    end else if (idx < 16'd28) begin
      source_host_reg_next = {source_host_reg_next[39:0], data_byte};
    end else if (idx < idprc_pkg::HEADER_BYTES) begin
      source_socket_reg_next = {source_socket_reg_next[7:0], data_byte};
    end else begin
      // Payload and pad bytes touch no header field.
    end

    // Checksum covers 16-bit words from byte 2 onward.
    if (idx >= 16'd2) begin
      if (!idx[0]) begin
        high_byte_hold_next = data_byte;
      end else begin
        sum_accum_next = fold_word(sum_accum_next, {high_byte_hold_next, data_byte});
      end
    end
  end

  // Classify the byte into a result request.
  always_comb begin
    last_index     = length_reg_next[0] ? length_reg_next : length_reg_next - 16'd1;
    emit           = 1'b0;
    kind           = idprc_pkg::KIND_HEADER;
    payload        = 8'd0;
    status         = idprc_pkg::STATUS_NONE;
    in_packet_next = 1'b1;
    priority if (idx < 16'd3) begin
      emit = 1'b0;
    end else if (idx == 16'd3 && length_reg_next < idprc_pkg::HEADER_BYTES) begin
      emit           = 1'b1;
      kind           = idprc_pkg::KIND_END;
      status         = idprc_pkg::STATUS_BAD_LEN;
      in_packet_next = 1'b0;
    end else if (idx < idprc_pkg::HEADER_BYTES - 16'd1) begin
      emit = 1'b0;
    end else if (idx >= last_index) begin
      emit           = 1'b1;
      kind           = idprc_pkg::KIND_END;
      in_packet_next = 1'b0;
      if (idx >= idprc_pkg::HEADER_BYTES && idx < length_reg_next) begin
        payload = data_byte;
      end
      priority if (received_checksum_next == no_checksum_value) begin
        status = idprc_pkg::STATUS_UNCHECKED;
      end else if (received_checksum_next == sum_accum_next) begin
        status = idprc_pkg::STATUS_OK;
      end else begin
        status = idprc_pkg::STATUS_MISMATCH;
      end
    end else if (idx == idprc_pkg::HEADER_BYTES - 16'd1) begin
      emit = 1'b1;
      kind = idprc_pkg::KIND_HEADER;
    end else begin
      emit    = 1'b1;
      kind    = idprc_pkg::KIND_PAYLOAD;
      payload = data_byte;
    end
  end

  // Request toward the queue, carrying the header as it stands now.
  always_comb begin
    push.valid              = active && emit;
    push.item.kind          = kind;
    push.item.payload_byte  = payload;
    push.item.end_status    = status;
    push.item.packet_length = length_reg_next;
    push.item.hop_count     = hop_reg_next;
    push.item.packet_type   = type_reg_next;
    push.item.dest_net      = dest_net_reg_next;
    push.item.dest_host     = dest_host_reg_next;
    push.item.dest_socket   = dest_socket_reg_next;
    push.item.source_net    = source_net_reg_next;
    push.item.source_host   = source_host_reg_next;
    push.item.source_socket = source_socket_reg_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet  <= 1'b0;
      byte_index <= 16'd0;
    end else if (active) begin
      in_packet  <= in_packet_next;
      byte_index <= idx + 16'd1;
    end
  end

  // Header and checksum registers; a first byte clears them.
  always_ff @(posedge clk) begin
    if (active) begin
      sum_accum         <= sum_accum_next;
      high_byte_hold    <= high_byte_hold_next;
      received_checksum <= received_checksum_next;
      length_reg        <= length_reg_next;
      hop_reg           <= hop_reg_next;
      type_reg          <= type_reg_next;
      dest_net_reg      <= dest_net_reg_next;
      dest_host_reg     <= dest_host_reg_next;
      dest_socket_reg   <= dest_socket_reg_next;
      source_net_reg    <= source_net_reg_next;
      source_host_reg   <= source_host_reg_next;
      source_socket_reg <= source_socket_reg_next;
    end
  end

endmodule
`default_nettype wire

[design/idprc_queue.sv]
// Back part: a small result queue whose head drives the output channel.
// Depends on idprc_pkg.
`default_nettype none
module idprc_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire idprc_pkg::push_t    push,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output idprc_pkg::result_t       head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  idprc_pkg::result_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;
  logic               wr_en;

  // Status and head of the queue.
  assign full      = (count == CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign wr_en     = push.valid && !full;
  assign head      = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= push.item;
    end
  end

endmodule
`default_nettype wire

[design/idp_packet_receive_checker_unit.sv]
// Datagram receive checker: takes one packet byte per cycle unless stalled, parses the
// 30-byte header, checks the rotating one's complement checksum and reports
// header, payload and end items. Depends on idprc_pkg, idprc_front, idprc_queue.
//
// The block accepts one byte per cycle while in_stall is low and turns it into at most
// one result, which is written into the result queue and reaches the output from its head.
// The parser and checksum fold are combinational, so a byte is finished in the cycle it is
// taken; a result queue of QUEUE_DEPTH entries (two by default) sits between parser and
// output, so input is stalled only while the queue is full. Status codes
// are 1 ok, 2 unchecked (checksum field equals no_checksum_value), 3
// mismatch and 4 bad length (length field below 30). The no_checksum_value
// register can be written at any time through cfg_valid/cfg_ready; ready is
// always high.
`default_nettype none
module idp_packet_receive_checker_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] no_checksum_value,
  // Byte input.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_byte,
  // Result output.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       payload_byte,
  output logic [2:0]       end_status,
  output logic [15:0]      packet_length,
  output logic [7:0]       hop_count,
  output logic [7:0]       packet_type,
  output logic [31:0]      dest_net,
  output logic [47:0]      dest_host,
  output logic [15:0]      dest_socket,
  output logic [31:0]      source_net,
  output logic [47:0]      source_host,
  output logic [15:0]      source_socket
);

  logic [15:0]        nocs_reg;
  idprc_pkg::push_t   push;
  idprc_pkg::result_t head;
  logic               full;

  // No-checksum register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      nocs_reg <= 16'hffff;
    end else if (cfg_valid && cfg_ready) begin
      nocs_reg <= no_checksum_value;
    end
  end

  assign in_stall = full;

  // Parser and checksum.
  idprc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .stall             (in_stall),
    .data_byte         (data_byte),
    .first_byte        (first_byte),
    .no_checksum_value (nocs_reg),
    .push              (push)
  );

  // Result queue and output.
  idprc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Output fields from the queue head.
  assign kind          = head.kind;
  assign payload_byte  = head.payload_byte;
  assign end_status    = head.end_status;
  assign packet_length = head.packet_length;
  assign hop_count     = head.hop_count;
  assign packet_type   = head.packet_type;
  assign dest_net      = head.dest_net;
  assign dest_host     = head.dest_host;
  assign dest_socket   = head.dest_socket;
  assign source_net    = head.source_net;
  assign source_host   = head.source_host;
  assign source_socket = head.source_socket;

endmodule
`default_nettype wire

[tb/testbench.sv]
// Testbench for idp_packet_receive_checker_unit: drives byte-wide datagram traffic and
// checks every header, payload and end item against a predictor kept in a small class.
// Depends on idprc_pkg and the design sources.
`timescale 1ns / 1ps

module testbench;

  localparam int GAP_NONE = 0;
  localparam int GAP_MIXED = 1;
  localparam int CK_GOOD = 0;
  localparam int CK_SKIP = 1;
  localparam int CK_RANDOM = 2;
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ONES = 1;
  localparam int FILL_ZEROS = 2;
  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_SHOWN = 10;

  // One end-around-carry add of a word followed by a rotate left by one.
  function automatic logic [15:0] fold_word(logic [15:0] acc, logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, w};
    if (s[16]) s = {1'b0, s[15:0] + 16'd1};
    s = {s[15:0], 1'b0};
    if (s[16]) s = {1'b0, s[15:0] + 16'd1};
    return s[15:0];
  endfunction

  // Random gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap(int mode);
    int r;
    if (mode == GAP_NONE) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Tracks the parser state and holds the items the block should produce.
  class datagram_tracker;
    logic [15:0] skip_value;
    logic [15:0] idx, sum, rx_cksum, len;
    logic [7:0] hold, hop, ptype;
    logic [31:0] dnet, snet;
    logic [47:0] dhost, shost;
    logic [15:0] dsock, ssock;
    logic active;
    idprc_pkg::result_t pending_items[$];
    int fail_count;

    function new();
      skip_value = 16'hFFFF;
      active = 1'b0;
      fail_count = 0;
      clear();
    endfunction

    function void clear();
      idx = '0; sum = '0; hold = '0; rx_cksum = '0; len = '0; hop = '0; ptype = '0;
      dnet = '0; dhost = '0; dsock = '0; snet = '0; shost = '0; ssock = '0;
    endfunction

    function void push_item(logic [1:0] k, logic [7:0] pb, logic [2:0] st);
      idprc_pkg::result_t r;
      r.kind = k;
      r.payload_byte = pb;
      r.end_status = st;
      r.packet_length = len;
      r.hop_count = hop;
      r.packet_type = ptype;
      r.dest_net = dnet;
      r.dest_host = dhost;
      r.dest_socket = dsock;
      r.source_net = snet;
      r.source_host = shost;
      r.source_socket = ssock;
      pending_items.push_back(r);
    endfunction

    // Called for every accepted byte request.
    function void take_byte(logic [7:0] b, logic f);
      logic [15:0] i;
      logic [15:0] end_index;
      logic [2:0] st;
      if (f) begin
        clear();
        active = 1'b1;
      end else if (!active) begin
        return;
      end
      i = idx;
      idx = idx + 16'd1;

      // Header fields shift in big-endian.
      if (i < 2) rx_cksum = {rx_cksum[7:0], b};
      else if (i < 4) len = {len[7:0], b};
      else if (i == 4) hop = b;
      else if (i == 5) ptype = b;
      else if (i < 10) dnet = {dnet[23:0], b};
      else if (i < 16) dhost = {dhost[39:0], b};
      else if (i < 18) dsock = {dsock[7:0], b};
      else if (i < 22) snet = {snet[23:0], b};
      else if (i < 28) shost = {shost[39:0], b};
      else if (i < idprc_pkg::HEADER_BYTES) ssock = {ssock[7:0], b};

      // Checksum words start at byte 2.
      if (i >= 2) begin
        if (!i[0]) hold = b;
        else sum = fold_word(sum, {hold, b});
      end

      if (i < 3) return;
      if (i == 3 && len < idprc_pkg::HEADER_BYTES) begin
        active = 1'b0;
        push_item(idprc_pkg::KIND_END, 8'h00, idprc_pkg::STATUS_BAD_LEN);
        return;
      end
      if (i < idprc_pkg::HEADER_BYTES - 1) return;

      end_index = len[0] ? len : len - 16'd1;
      if (i >= end_index) begin
        if (rx_cksum == skip_value) st = idprc_pkg::STATUS_UNCHECKED;
        else if (rx_cksum == sum) st = idprc_pkg::STATUS_OK;
        else st = idprc_pkg::STATUS_MISMATCH;
        active = 1'b0;
        push_item(idprc_pkg::KIND_END,
                  (i >= idprc_pkg::HEADER_BYTES && i < len) ? b : 8'h00, st);
        return;
      end
      if (i == idprc_pkg::HEADER_BYTES - 1)
        push_item(idprc_pkg::KIND_HEADER, 8'h00, idprc_pkg::STATUS_NONE);
      else push_item(idprc_pkg::KIND_PAYLOAD, b, idprc_pkg::STATUS_NONE);
    endfunction

    function void note_fail(string what, logic [63:0] want, logic [63:0] got);
      fail_count++;
      if (fail_count <= MAX_SHOWN)
        $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    // Called for every accepted result.
    function void match_item(idprc_pkg::result_t got);
      idprc_pkg::result_t want;
      if (pending_items.size() == 0) begin
        note_fail("result with nothing pending, kind", 64'd0, got.kind);
        return;
      end
      want = pending_items.pop_front();
      if (got.kind !== want.kind) note_fail("kind", want.kind, got.kind);
      if (got.payload_byte !== want.payload_byte)
        note_fail("payload_byte", want.payload_byte, got.payload_byte);
      if (got.end_status !== want.end_status)
        note_fail("end_status", want.end_status, got.end_status);
      if (got.packet_length !== want.packet_length)
        note_fail("packet_length", want.packet_length, got.packet_length);
      if (got.hop_count !== want.hop_count)
        note_fail("hop_count", want.hop_count, got.hop_count);
      if (got.packet_type !== want.packet_type)
        note_fail("packet_type", want.packet_type, got.packet_type);
      if (got.dest_net !== want.dest_net) note_fail("dest_net", want.dest_net, got.dest_net);
      if (got.dest_host !== want.dest_host)
        note_fail("dest_host", want.dest_host, got.dest_host);
      if (got.dest_socket !== want.dest_socket)
        note_fail("dest_socket", want.dest_socket, got.dest_socket);
      if (got.source_net !== want.source_net)
        note_fail("source_net", want.source_net, got.source_net);
      if (got.source_host !== want.source_host)
        note_fail("source_host", want.source_host, got.source_host);
      if (got.source_socket !== want.source_socket)
        note_fail("source_socket", want.source_socket, got.source_socket);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] no_checksum_value = 16'h0000;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = 8'h00;
  logic first_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic [2:0] end_status;
  logic [15:0] packet_length;
  logic [7:0] hop_count;
  logic [7:0] packet_type;
  logic [31:0] dest_net;
  logic [47:0] dest_host;
  logic [15:0] dest_socket;
  logic [31:0] source_net;
  logic [47:0] source_host;
  logic [15:0] source_socket;

  datagram_tracker tracker = new();
  int tx_gap_mode = GAP_MIXED;
  int rx_gap_mode = GAP_MIXED;
  bit hold_off_req = 1'b0;
  int unsigned counted_bytes = 0;
  int cycle_count = 0;

  idp_packet_receive_checker_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .no_checksum_value(no_checksum_value),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .first_byte(first_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .payload_byte(payload_byte),
    .end_status(end_status),
    .packet_length(packet_length),
    .hop_count(hop_count),
    .packet_type(packet_type),
    .dest_net(dest_net),
    .dest_host(dest_host),
    .dest_socket(dest_socket),
    .source_net(source_net),
    .source_host(source_host),
    .source_socket(source_socket)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[idp_packet_receive_checker_unit] ERROR");
      $finish;
    end
  end

  // Every accepted result goes to the tracker.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.match_item({kind, payload_byte, end_status, packet_length, hop_count,
                          packet_type, dest_net, dest_host, dest_socket, source_net,
                          source_host, source_socket});
  end

  // Receiver stall: random gaps, or one long hold-off when asked for.
  initial begin : rx_stall_driver
    int n;
    forever begin
      if (hold_off_req) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        n = pick_gap(rx_gap_mode);
        if (n > 0) begin
          @(negedge clk);
          out_stall <= 1'b1;
          repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one byte request and wait until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic f);
    int gap;
    gap = pick_gap(tx_gap_mode);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    first_byte <= f;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(b, f);
  endtask

  // Build a datagram of the given length and send its first cut bytes.
  task automatic send_packet(input logic [15:0] plen, input int ck_mode, input int fill_mode,
                             input int unsigned cut);
    logic [7:0] pkt[];
    int unsigned total, n, k;
    logic [15:0] sum;
    total = (plen < idprc_pkg::HEADER_BYTES) ? idprc_pkg::HEADER_BYTES : plen + plen[0];
    pkt = new[total];
    foreach (pkt[j]) begin
      if (fill_mode == FILL_ONES) pkt[j] = 8'hFF;
      else if (fill_mode == FILL_ZEROS) pkt[j] = 8'h00;
      else pkt[j] = 8'($urandom_range(0, 255));
    end
    pkt[2] = plen[15:8];
    pkt[3] = plen[7:0];
    sum = 16'h0000;
    for (k = 2; k + 1 < total; k += 2) sum = fold_word(sum, {pkt[k], pkt[k + 1]});
    if (ck_mode == CK_SKIP) sum = tracker.skip_value;
    else if (ck_mode == CK_RANDOM) sum = 16'($urandom_range(0, 65535));
    pkt[0] = sum[15:8];
    pkt[1] = sum[7:0];
    n = (cut < total) ? cut : total;
    for (k = 0; k < n; k++) send_byte(pkt[k], k == 0);
    counted_bytes += n;
  endtask

  // Lower valid and let every pending result arrive.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_items.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the no-checksum register; only called while the block is idle.
  task automatic write_skip_value(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    no_checksum_value <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.skip_value = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed packets, with truncated ones, bad lengths and stray bytes.
  task automatic run_random(input int unsigned budget);
    int r, m, ck, fill;
    int unsigned plen, extra;
    counted_bytes = 0;
    while (counted_bytes < budget) begin
      r = $urandom_range(0, 99);
      m = $urandom_range(0, 99);
      ck = (m < 50) ? CK_GOOD : (m < 70) ? CK_SKIP : CK_RANDOM;
      m = $urandom_range(0, 99);
      fill = (m < 92) ? FILL_RANDOM : (m < 96) ? FILL_ONES : FILL_ZEROS;
      if (r < 70) begin
        m = $urandom_range(0, 99);
        if (m < 80) plen = $urandom_range(30, 44);
        else if (m < 95) plen = $urandom_range(45, 120);
        else plen = $urandom_range(121, 300);
        send_packet(16'(plen), ck, fill, 32'hFFFF_FFFF);
      end else if (r < 80) begin
        plen = $urandom_range(30, 65535);
        send_packet(16'(plen), ck, fill, $urandom_range(1, 40));
      end else if (r < 88) begin
        send_packet(16'($urandom_range(0, 29)), ck, fill, 4);
        extra = $urandom_range(0, 3);
        repeat (extra) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  // Main sequence.
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: stray bytes while idle, bad lengths at both ends, a huge length cut short.
    write_skip_value(16'hFFFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_packet(16'd0, CK_RANDOM, FILL_ZEROS, 4);
    send_packet(16'd29, CK_RANDOM, FILL_ONES, 4);
    send_packet(16'hFFFF, CK_RANDOM, FILL_ONES, 8);

    // Header-only, odd and even lengths, then random traffic at the reset setting.
    send_packet(16'd30, CK_GOOD, FILL_ONES, 32'hFFFF_FFFF);
    send_packet(16'd31, CK_SKIP, FILL_ZEROS, 32'hFFFF_FFFF);
    send_packet(16'd32, CK_RANDOM, FILL_RANDOM, 32'hFFFF_FFFF);
    run_random(560);
    drain_results();

    // Back-to-back input while the receiver holds off, so the block stalls its input.
    write_skip_value(16'h0000);
    tx_gap_mode = GAP_NONE;
    hold_off_req = 1'b1;
    run_random(400);
    drain_results();

    // Random setting with gaps on both sides.
    tx_gap_mode = GAP_MIXED;
    write_skip_value(16'($urandom_range(0, 65535)));
    run_random(600);
    drain_results();

    // Full rate on both sides.
    tx_gap_mode = GAP_NONE;
    rx_gap_mode = GAP_NONE;
    write_skip_value(16'($urandom_range(0, 65535)));
    run_random(300);
    drain_results();

    repeat (16) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.pending_items.size() == 0) begin
      $display("[idp_packet_receive_checker_unit] OK");
    end else begin
      $display("[idp_packet_receive_checker_unit] ERROR");
    end
    $finish;
  end

endmodule

[idp_packet_receive_checker_unit.f]
design/idprc_pkg.sv
design/idprc_front.sv
design/idprc_queue.sv
design/idp_packet_receive_checker_unit.sv
tb/testbench.sv
